[sv/window_inclusion_density_check_defines.svh]
// Assertion macros shared by the window inclusion density check checker.
`ifndef WINDOW_INCLUSION_DENSITY_CHECK_DEFINES_SVH
`define WINDOW_INCLUSION_DENSITY_CHECK_DEFINES_SVH

// same-cycle implication
`define WIDC_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WIDC_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/widc_pkg.sv]
// Constants and codes for the window inclusion density check.
package widc_pkg;

   localparam int FLAW_DEPTH  = 256;
   localparam int FLAW_IDX_W  = $clog2(FLAW_DEPTH);
   localparam int RING_DEPTH  = 256;
   localparam int PTR_W       = $clog2(RING_DEPTH);
   localparam int WCOLS_W     = 9;
   localparam int THR_W       = 21;
   localparam int ELONG_W     = 16;
   localparam int COUNT_W     = 13;
   localparam int TOTAL_W     = 21;
   localparam int COLNUM_W    = 12;
   localparam int OP_W        = 2;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;
   localparam logic [COLNUM_W-1:0] COLNUM_MAX = '1;
   localparam logic [WCOLS_W-1:0]  WIDTH_MAX  = WCOLS_W'(RING_DEPTH);

   // operation codes
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_PIXEL = 2'd2;

   // register indexes
   localparam logic [1:0] REG_WINDOW_COLS = 2'd0;
   localparam logic [1:0] REG_THRESHOLD_A = 2'd1;
   localparam logic [1:0] REG_THRESHOLD_B = 2'd2;
   localparam logic [1:0] REG_ELONG_LIMIT = 2'd3;

   localparam logic [WCOLS_W-1:0] WINDOW_COLS_RST = 9'd64;
   localparam logic [ELONG_W-1:0] ELONG_LIMIT_RST = 16'd1280;

endpackage

[sv/window_inclusion_density_check.sv]
// The result of an image-end pixel word passes through the stage one register, then the result register.
// Throughput: one word per cycle; input stalls only while an image-end word waits on rsp_stall.
// Flaw class table and column ring: one write port and one registered read port each.
// Synchronous reset clears the flaw loaded bits, the image counters and the registers.
// The column ring is not cleared; entries are always written before they are read.
module window_inclusion_density_check
   import widc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [FLAW_IDX_W-1:0] req_flaw_index,
   input  logic [ELONG_W-1:0]    req_elongation,
   input  logic                  req_pixel_set,
   input  logic                  req_last_in_column,
   input  logic                  req_last_in_image,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_fail_a,
   output logic [COLNUM_W-1:0]   rsp_first_window_a,
   output logic                  rsp_fail_b,
   output logic [COLNUM_W-1:0]   rsp_first_window_b,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // configuration
   logic [WCOLS_W-1:0] window_cols_ff;
   logic [THR_W-1:0]   threshold_a_ff, threshold_b_ff;
   logic [ELONG_W-1:0] elong_limit_ff;
   logic               csr_wr;
   logic [1:0]         csr_idx;

   // stage one word
   logic                  s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]       s1_operation_ff;
   logic [FLAW_IDX_W-1:0] s1_index_ff;
   logic [ELONG_W-1:0]    s1_elong_ff;
   logic                  s1_pixel_ff, s1_lcol_ff, s1_limg_ff;

   // flaw table
   logic [FLAW_DEPTH-1:0] flaw_loaded_ff, flaw_loaded_in;
   logic                  flaw_incl_ff [FLAW_DEPTH];
   logic                  incl_rd_ff;
   logic                  incl_we;
   logic                  incl_wdata;

   // column ring
   logic [COUNT_W-1:0] column_ring_ff [RING_DEPTH];
   logic [COUNT_W-1:0] ring_rd_ff;
   logic               ring_we;
   logic [PTR_W-1:0]   ring_rd_addr;

   // image state
   logic [COUNT_W-1:0]  cur_count_ff, cur_count_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [COLNUM_W-1:0] colnum_ff, colnum_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic                found_a_ff, found_a_in, found_b_ff, found_b_in;
   logic [COLNUM_W-1:0] pos_a_ff, pos_a_in, pos_b_ff, pos_b_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                fail_a_ff, fail_b_ff;
   logic [COLNUM_W-1:0] first_a_ff, first_b_ff;

   // datapath
   logic                s1_result, s1_block, s1_go, accept;
   logic                is_start, is_load, is_pixel, finish;
   logic [WCOLS_W-1:0]  width_eff;
   logic [COLNUM_W-1:0] width_ext;
   logic [PTR_W-1:0]    ptr_eff, ptr_next;
   logic [WCOLS_W-1:0]  ptr_inc;
   logic                count_inc;
   logic [COUNT_W-1:0]  count_new;
   logic [TOTAL_W-1:0]  total_sub, total_new;
   logic [TOTAL_W:0]    total_sum;
   logic [COLNUM_W-1:0] colnum_new, start_col;
   logic                window_full, hit_a, hit_b;
   logic                found_a_new, found_b_new;
   logic [COLNUM_W-1:0] pos_a_new, pos_b_new;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_cols_ff <= WINDOW_COLS_RST;
         threshold_a_ff <= '0;
         threshold_b_ff <= '0;
         elong_limit_ff <= ELONG_LIMIT_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_WINDOW_COLS: window_cols_ff <= pwdata[WCOLS_W-1:0];
            REG_THRESHOLD_A: threshold_a_ff <= pwdata[THR_W-1:0];
            REG_THRESHOLD_B: threshold_b_ff <= pwdata[THR_W-1:0];
            REG_ELONG_LIMIT: elong_limit_ff <= pwdata[ELONG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_WINDOW_COLS: prdata = CSR_DATA_W'(window_cols_ff);
         REG_THRESHOLD_A: prdata = CSR_DATA_W'(threshold_a_ff);
         REG_THRESHOLD_B: prdata = CSR_DATA_W'(threshold_b_ff);
         REG_ELONG_LIMIT: prdata = CSR_DATA_W'(elong_limit_ff);
         default:         prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   assign is_start  = (s1_operation_ff == OP_START);
   assign is_load   = (s1_operation_ff == OP_LOAD);
   assign is_pixel  = (s1_operation_ff == OP_PIXEL);
   assign s1_result = is_pixel & s1_limg_ff;
   // only an image-end word can be held, and only by a waiting result
   assign s1_block  = s1_valid_ff & s1_result & rsp_valid_ff & rsp_stall;
   assign s1_go     = s1_valid_ff & ~s1_block;
   assign req_stall = s1_block;
   assign accept    = req_valid & ~req_stall;

   assign s1_valid_in  = accept | (s1_valid_ff & ~s1_go);
   assign rsp_valid_in = (s1_go & s1_result) | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_operation_ff <= req_operation;
         s1_index_ff     <= req_flaw_index;
         s1_elong_ff     <= req_elongation;
         s1_pixel_ff     <= req_pixel_set;
         s1_lcol_ff      <= req_last_in_column;
         s1_limg_ff      <= req_last_in_image;
      end
   end

   // ---------------- flaw table ----------------
   assign incl_we    = s1_go & is_load & ~flaw_loaded_ff[s1_index_ff];
   assign incl_wdata = (s1_elong_ff <= elong_limit_ff);

   always_comb begin
      flaw_loaded_in = flaw_loaded_ff;
      if (s1_go && is_start) begin
         flaw_loaded_in = '0;
      end else if (incl_we) begin
         flaw_loaded_in[s1_index_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flaw_loaded_ff <= '0;
      end else begin
         flaw_loaded_ff <= flaw_loaded_in;
      end
   end

   // read at accept; a load leaving stage one at the same edge is forwarded
   always_ff @(posedge clock) begin
      if (incl_we) begin
         flaw_incl_ff[s1_index_ff] <= incl_wdata;
      end
      if (accept) begin
         if (incl_we && s1_index_ff == req_flaw_index) begin
            incl_rd_ff <= incl_wdata;
         end else begin
            incl_rd_ff <= flaw_incl_ff[req_flaw_index];
         end
      end
   end

   // ---------------- column window ----------------
   always_comb begin
      if (window_cols_ff == '0) begin
         width_eff = WCOLS_W'(1);
      end else if (window_cols_ff > WIDTH_MAX) begin
         width_eff = WIDTH_MAX;
      end else begin
         width_eff = window_cols_ff;
      end
   end
   assign width_ext = COLNUM_W'(width_eff);

   assign ptr_eff  = ({1'b0, ptr_ff} >= width_eff) ? '0 : ptr_ff;
   assign ptr_inc  = {1'b0, ptr_eff} + WCOLS_W'(1);
   assign ptr_next = (ptr_inc >= width_eff) ? '0 : ptr_inc[PTR_W-1:0];

   assign finish    = is_pixel & (s1_lcol_ff | s1_limg_ff);
   assign count_inc = is_pixel & s1_pixel_ff & flaw_loaded_ff[s1_index_ff] & incl_rd_ff
                      & (cur_count_ff != COUNT_MAX);
   assign count_new = cur_count_ff + COUNT_W'(count_inc);

   // ring_rd_ff already holds the entry at the current pointer
   always_comb begin
      if (colnum_ff >= width_ext) begin
         total_sub = (total_ff > TOTAL_W'(ring_rd_ff)) ? total_ff - TOTAL_W'(ring_rd_ff) : '0;
      end else begin
         total_sub = total_ff;
      end
   end
   assign total_sum   = {1'b0, total_sub} + (TOTAL_W+1)'(count_new);
   assign total_new   = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
   assign colnum_new  = (colnum_ff == COLNUM_MAX) ? colnum_ff : colnum_ff + COLNUM_W'(1);
   assign window_full = (colnum_new >= width_ext);
   assign start_col   = colnum_new - width_ext;
   assign hit_a       = window_full & ~found_a_ff & (total_new > threshold_a_ff);
   assign hit_b       = window_full & ~found_b_ff & (total_new > threshold_b_ff);
   assign found_a_new = found_a_ff | hit_a;
   assign found_b_new = found_b_ff | hit_b;
   assign pos_a_new   = hit_a ? start_col : pos_a_ff;
   assign pos_b_new   = hit_b ? start_col : pos_b_ff;

   assign ring_we      = s1_go & finish;
   // prefetch the entry that the next column end will retire
   assign ring_rd_addr = ({1'b0, ptr_in} >= width_eff) ? '0 : ptr_in;

   always_ff @(posedge clock) begin
      if (ring_we) begin
         column_ring_ff[ptr_eff] <= count_new;
      end
      if (ring_we && ptr_eff == ring_rd_addr) begin
         ring_rd_ff <= count_new;
      end else begin
         ring_rd_ff <= column_ring_ff[ring_rd_addr];
      end
   end

   always_comb begin
      cur_count_in = cur_count_ff;
      total_in     = total_ff;
      colnum_in    = colnum_ff;
      ptr_in       = ptr_ff;
      found_a_in   = found_a_ff;
      found_b_in   = found_b_ff;
      pos_a_in     = pos_a_ff;
      pos_b_in     = pos_b_ff;
      if (s1_go) begin
         if (is_start || s1_result) begin
            // image end and start both leave a clean image state
            cur_count_in = '0;
            total_in     = '0;
            colnum_in    = '0;
            ptr_in       = '0;
            found_a_in   = 1'b0;
            found_b_in   = 1'b0;
            pos_a_in     = '0;
            pos_b_in     = '0;
         end else if (finish) begin
            cur_count_in = '0;
            total_in     = total_new;
            colnum_in    = colnum_new;
            ptr_in       = ptr_next;
            found_a_in   = found_a_new;
            found_b_in   = found_b_new;
            pos_a_in     = pos_a_new;
            pos_b_in     = pos_b_new;
         end else if (is_pixel) begin
            cur_count_in = count_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_count_ff <= '0;
         total_ff     <= '0;
         colnum_ff    <= '0;
         ptr_ff       <= '0;
         found_a_ff   <= 1'b0;
         found_b_ff   <= 1'b0;
         pos_a_ff     <= '0;
         pos_b_ff     <= '0;
      end else begin
         cur_count_ff <= cur_count_in;
         total_ff     <= total_in;
         colnum_ff    <= colnum_in;
         ptr_ff       <= ptr_in;
         found_a_ff   <= found_a_in;
         found_b_ff   <= found_b_in;
         pos_a_ff     <= pos_a_in;
         pos_b_ff     <= pos_b_in;
      end
   end

   // ---------------- result word ----------------
   always_ff @(posedge clock) begin
      if (s1_go && s1_result) begin
         fail_a_ff  <= found_a_new;
         fail_b_ff  <= found_b_new;
         first_a_ff <= found_a_new ? pos_a_new : '0;
         first_b_ff <= found_b_new ? pos_b_new : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fail_a         = fail_a_ff;
   assign rsp_first_window_a = first_a_ff;
   assign rsp_fail_b         = fail_b_ff;
   assign rsp_first_window_b = first_b_ff;

endmodule

[sv/widc_checker.sv]
// Port-level checker for the window inclusion density check, bound to the top level.
`include "window_inclusion_density_check_defines.svh"

module widc_checker
   import widc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [OP_W-1:0]     req_operation,
   input logic                req_last_in_image,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic                rsp_fail_a,
   input logic [COLNUM_W-1:0] rsp_first_window_a,
   input logic                rsp_fail_b,
   input logic [COLNUM_W-1:0] rsp_first_window_b
);

   logic img_end_word;

   assign img_end_word = req_valid & ~req_stall & (req_operation == OP_PIXEL)
                         & req_last_in_image;

   // a fresh result follows an accepted image-end word, through stage one and the result register
   `WIDC_ASSERT_IMP(a_rsp_from_image_end, clock, reset, $rose(rsp_valid), $past(img_end_word, 2), "result without an image-end word")

   // window start only reported on failure
   `WIDC_ASSERT_IMP(a_pos_a_zero, clock, reset, rsp_valid && !rsp_fail_a, rsp_first_window_a == '0, "first_window_a set without fail_a")
   `WIDC_ASSERT_IMP(a_pos_b_zero, clock, reset, rsp_valid && !rsp_fail_b, rsp_first_window_b == '0, "first_window_b set without fail_b")

   `WIDC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fail_a) && $stable(rsp_first_window_a) && $stable(rsp_fail_b) && $stable(rsp_first_window_b), "stalled result word changed")

endmodule

bind window_inclusion_density_check widc_checker u_widc_checker (.*);
